>>> hdl/premultiplied_alpha_pixel_blender_defines.svh
// assertion macros for the premultiplied alpha pixel blender checker
// no dependencies; included by the checker file only
`ifndef PREMULTIPLIED_ALPHA_PIXEL_BLENDER_DEFINES_SVH
`define PREMULTIPLIED_ALPHA_PIXEL_BLENDER_DEFINES_SVH

// property that must hold at every edge out of reset
`define PBL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pixel blender check failed");

// consequent must hold in the cycle after the antecedent
`define PBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel blender check failed");

`endif

>>> hdl/pbl_pkg.sv
// shared types, constants and helpers for the pixel blender
// no dependencies
package pbl_pkg;

    localparam int CH_W    = 8;
    localparam int NUM_CH  = 4;
    localparam int RATE_W  = 9;
    localparam int PROD_W  = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int TYPE_W  = 3;

    localparam logic [RATE_W-1:0] RATE_ONE   = 9'd256;
    localparam logic [CH_W-1:0]   CH_MAX     = 8'd255;
    localparam logic [RATE_W-1:0] RATE_RESET = 9'd256;
    localparam logic [DATA_W-1:0] FILL_RESET = 32'd0;

    // channel positions, alpha first
    localparam int CH_A = 0;

    typedef enum logic [TYPE_W-1:0] {
        OP_CONVERT  = 3'd0,
        OP_SCALE    = 3'd1,
        OP_OVER     = 3'd2,
        OP_XLUCENT  = 3'd3,
        OP_FILL     = 3'd4,
        OP_PREFILL  = 3'd5
    } op_t;

    typedef enum logic {
        REG_RATE = 1'b0,
        REG_FILL = 1'b1
    } reg_idx_t;

    // controls shared by all four channel datapaths
    typedef struct packed {
        op_t               op;
        logic [RATE_W-1:0] w;
        logic [RATE_W-1:0] k_src;
        logic [RATE_W-1:0] k_fill;
        logic              fill_clear;
    } chan_ctl_t;

    // alpha weight: a + (a > 0)
    function automatic logic [RATE_W-1:0] alpha_weight(input logic [CH_W-1:0] a);
        return {1'b0, a} + {{(RATE_W-1){1'b0}}, (a != '0)};
    endfunction

endpackage

>>> hdl/pbl_chan.sv
// one 8-bit channel of the blend datapath, all operations muxed by op code
// depends on pbl_pkg
module pbl_chan (
    input  pbl_pkg::chan_ctl_t        ctl,
    input  logic                      is_alpha,
    input  logic [pbl_pkg::CH_W-1:0]  src,
    input  logic [pbl_pkg::CH_W-1:0]  dst,
    input  logic [pbl_pkg::CH_W-1:0]  fill,
    output logic [pbl_pkg::CH_W-1:0]  res
);

    logic [pbl_pkg::PROD_W-1:0] prod_s_k;
    logic [pbl_pkg::PROD_W-1:0] prod_s_w;
    logic [pbl_pkg::PROD_W-1:0] prod_d_ks;
    logic [pbl_pkg::PROD_W-1:0] prod_d_kf;
    logic [pbl_pkg::PROD_W-1:0] prod_d_w;
    logic [pbl_pkg::PROD_W-1:0] prod_f_w;
    logic [pbl_pkg::PROD_W-1:0] mix;
    logic [pbl_pkg::CH_W-1:0]   fill_x;
    logic [pbl_pkg::CH_W-1:0]   over_src;
    logic [pbl_pkg::CH_W-1:0]   over_fill;

    // products, each 8 x 9 bits and below 2^16
    always_comb begin
        fill_x    = is_alpha ? pbl_pkg::CH_MAX : fill;
        prod_s_k  = pbl_pkg::PROD_W'(src) * pbl_pkg::PROD_W'(ctl.k_src);
        prod_s_w  = pbl_pkg::PROD_W'(src) * pbl_pkg::PROD_W'(ctl.w);
        prod_d_ks = pbl_pkg::PROD_W'(dst) * pbl_pkg::PROD_W'(pbl_pkg::RATE_ONE - ctl.k_src);
        prod_d_kf = pbl_pkg::PROD_W'(dst) * pbl_pkg::PROD_W'(pbl_pkg::RATE_ONE - ctl.k_fill);
        prod_d_w  = pbl_pkg::PROD_W'(dst) * pbl_pkg::PROD_W'(pbl_pkg::RATE_ONE - ctl.w);
        prod_f_w  = pbl_pkg::PROD_W'(fill_x) * pbl_pkg::PROD_W'(ctl.w);
        mix       = prod_d_w + prod_s_w;
        over_src  = prod_d_ks[15:8] + src;
        over_fill = prod_d_kf[15:8] + fill;
    end

    // result select
    always_comb begin
        unique case (ctl.op)
            pbl_pkg::OP_CONVERT: res = is_alpha ? src : prod_s_k[15:8];
            pbl_pkg::OP_SCALE:   res = prod_s_w[15:8];
            pbl_pkg::OP_OVER:    res = over_src;
            pbl_pkg::OP_XLUCENT: res = (ctl.w == pbl_pkg::RATE_ONE) ? over_src : mix[15:8];
            pbl_pkg::OP_FILL:    res = prod_d_w[15:8] + prod_f_w[15:8];
            pbl_pkg::OP_PREFILL: res = ctl.fill_clear ? dst : over_fill;
            default:             res = dst;
        endcase
    end

endmodule

>>> hdl/premultiplied_alpha_pixel_blender.sv
// Premultiplied ARGB8888 blender: an input transfer passes the input register, then the
// result register, before m_valid; throughput one pixel per clock while m_ready is not
// held low, set by the single registered pass through four parallel channel datapaths.
// Reset (aresetn low, synchronous) empties both stages, blend_rate = 256, fill_color = 0.
// Depends on pbl_pkg and pbl_chan.
module premultiplied_alpha_pixel_blender (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pbl_pkg::TYPE_W-1:0]    s_req_type,
    input  logic [pbl_pkg::CH_W-1:0]      s_src_a,
    input  logic [pbl_pkg::CH_W-1:0]      s_src_r,
    input  logic [pbl_pkg::CH_W-1:0]      s_src_g,
    input  logic [pbl_pkg::CH_W-1:0]      s_src_b,
    input  logic [pbl_pkg::CH_W-1:0]      s_dst_a,
    input  logic [pbl_pkg::CH_W-1:0]      s_dst_r,
    input  logic [pbl_pkg::CH_W-1:0]      s_dst_g,
    input  logic [pbl_pkg::CH_W-1:0]      s_dst_b,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pbl_pkg::CH_W-1:0]      m_out_a,
    output logic [pbl_pkg::CH_W-1:0]      m_out_r,
    output logic [pbl_pkg::CH_W-1:0]      m_out_g,
    output logic [pbl_pkg::CH_W-1:0]      m_out_b,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbl_pkg::ADDR_W-1:0]    paddr,
    input  logic [pbl_pkg::DATA_W-1:0]    pwdata,
    output logic [pbl_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [pbl_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic [pbl_pkg::DATA_W-1:0] fill_reg, fill_next;
    pbl_pkg::reg_idx_t          reg_idx;
    logic                       cfg_wr;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        s1_adv;
    logic                        s_xfer;
    logic [pbl_pkg::TYPE_W-1:0]  type_reg;
    logic [pbl_pkg::NUM_CH-1:0][pbl_pkg::CH_W-1:0] src_reg, dst_reg;
    logic [pbl_pkg::NUM_CH-1:0][pbl_pkg::CH_W-1:0] fill_ch, res_ch, out_reg;

    pbl_pkg::chan_ctl_t ctl;

    // register file decode
    assign pready  = 1'b1;
    assign reg_idx = pbl_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        rate_next = rate_reg;
        fill_next = fill_reg;
        prdata    = '0;
        unique case (reg_idx)
            pbl_pkg::REG_RATE: begin
                prdata = pbl_pkg::DATA_W'(rate_reg);
                if (cfg_wr) begin
                    rate_next = pwdata[pbl_pkg::RATE_W-1:0];
                end
            end
            pbl_pkg::REG_FILL: begin
                prdata = fill_reg;
                if (cfg_wr) begin
                    fill_next = pwdata;
                end
            end
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= pbl_pkg::RATE_RESET;
            fill_reg <= pbl_pkg::FILL_RESET;
        end else begin
            rate_reg <= rate_next;
            fill_reg <= fill_next;
        end
    end

    // pipeline flow control
    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        s1_valid_next = s_ready ? s_valid : s1_valid_reg;
        m_valid_next  = s1_adv ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            type_reg <= s_req_type;
            src_reg  <= {s_src_b, s_src_g, s_src_r, s_src_a};
            dst_reg  <= {s_dst_b, s_dst_g, s_dst_r, s_dst_a};
        end
    end

    // shared channel controls; rate above 256 saturates
    always_comb begin
        ctl.op         = pbl_pkg::op_t'(type_reg);
        ctl.w          = rate_reg[pbl_pkg::RATE_W-1] ? pbl_pkg::RATE_ONE : rate_reg;
        ctl.k_src      = pbl_pkg::alpha_weight(src_reg[pbl_pkg::CH_A]);
        ctl.k_fill     = pbl_pkg::alpha_weight(fill_reg[31:24]);
        ctl.fill_clear = (fill_reg[31:24] == '0);
        fill_ch        = {fill_reg[7:0], fill_reg[15:8], fill_reg[23:16], fill_reg[31:24]};
    end

    // per-channel datapaths
    for (genvar i = 0; i < pbl_pkg::NUM_CH; i++) begin : g_chan
        pbl_chan u_chan (
            .ctl      (ctl),
            .is_alpha (i == pbl_pkg::CH_A),
            .src      (src_reg[i]),
            .dst      (dst_reg[i]),
            .fill     (fill_ch[i]),
            .res      (res_ch[i])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            out_reg <= res_ch;
        end
    end

    assign m_out_a = out_reg[0];
    assign m_out_r = out_reg[1];
    assign m_out_g = out_reg[2];
    assign m_out_b = out_reg[3];

endmodule

>>> hdl/pbl_checker.sv
// port-level checks for the pixel blender, bound to the top level
// depends on pbl_pkg and premultiplied_alpha_pixel_blender_defines.svh
`include "premultiplied_alpha_pixel_blender_defines.svh"

module pbl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pbl_pkg::CH_W-1:0]      m_out_a,
    input logic [pbl_pkg::CH_W-1:0]      m_out_r,
    input logic [pbl_pkg::CH_W-1:0]      m_out_g,
    input logic [pbl_pkg::CH_W-1:0]      m_out_b,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [pbl_pkg::ADDR_W-1:0]    paddr,
    input logic [pbl_pkg::DATA_W-1:0]    pwdata,
    input logic [pbl_pkg::DATA_W-1:0]    prdata,
    input logic                          pready
);

    logic [pbl_pkg::NUM_CH*pbl_pkg::CH_W-1:0] out_pix;
    logic                                     fill_wr;

    // whole output pixel and fill colour write strobe
    assign out_pix = {m_out_a, m_out_r, m_out_g, m_out_b};
    assign fill_wr = psel && penable && pwrite && pready && paddr[2];

    // a stalled result holds its pixel
    `PBL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_pix))

    // no input back-pressure while the result side drains
    `PBL_ASSERT(a_ready_follows, aclk, aresetn, !m_ready || s_ready)

    // a transfer reaches the output through the input and result registers when not stalled
    `PBL_ASSERT_NEXT(a_latency, aclk, aresetn, (s_valid && s_ready) ##1 m_ready, m_valid)

    // fill colour write reads back in full
    `PBL_ASSERT(a_fill_read, aclk, aresetn, (fill_wr ##1 paddr[2]) |-> (prdata == $past(pwdata)))

endmodule

bind premultiplied_alpha_pixel_blender pbl_checker u_pbl_checker (.*);
